// ----- rtl/rpl_pkg.sv -----
// Shared types and constants of the region penalty lookup.
package rpl_pkg;

	localparam int BOX_ENTRIES_DEF  = 16;
	localparam int POLY_ENTRIES_DEF = 16;
	localparam int MAX_VERTICES_DEF = 8;
	localparam int COORD_W = 24;
	localparam int IN_DATA_W  = 184;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_QUERY     = 2'd0,
		OP_BOX       = 2'd1,
		OP_POLY_HDR  = 2'd2,
		OP_POLY_VERT = 2'd3
	} op_e_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_BOX_RD, ST_BOX_EV, ST_HDR_RD, ST_HDR_EV,
		ST_V_PREV, ST_V_CUR, ST_MUL1, ST_MUL2, ST_CMP, ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0]                cost;
		logic signed [COORD_W-1:0] zmax;
		logic signed [COORD_W-1:0] ymax;
		logic signed [COORD_W-1:0] xmax;
		logic signed [COORD_W-1:0] zmin;
		logic signed [COORD_W-1:0] ymin;
		logic signed [COORD_W-1:0] xmin;
		logic [15:0]               map;
	} box_entry_t;

	typedef struct packed {
		logic [7:0]                cost;
		logic signed [COORD_W-1:0] zmax;
		logic signed [COORD_W-1:0] zmin;
		logic [15:0]               map;
	} poly_hdr_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} vertex_t;

endpackage

// ----- rtl/rpl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/region_penalty_lookup.sv -----
// Top level of the region penalty lookup: region tables, query sequencer and stream ports.
//
// Loads (box, polygon header, polygon vertex) are written while the block is idle. A query
// walks every box entry (read, then evaluate), every polygon header (read, then evaluate), and
// for each polygon of the query's map whose height band holds the point it reads the closing
// vertex and then steps through the edges, forming and comparing the two products only for
// an edge that the ray crosses, all through one shared 25x25 multiplier and comparator.
// The input is not ready while a query runs.
// Tables are in RAM and undefined until written; valid bits and vertex counts reset to zero.
module region_penalty_lookup
	import rpl_pkg::*;
#(
	parameter int BOX_ENTRIES  = rpl_pkg::BOX_ENTRIES_DEF,
	parameter int POLY_ENTRIES = rpl_pkg::POLY_ENTRIES_DEF,
	parameter int MAX_VERTICES = rpl_pkg::MAX_VERTICES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// slot, vertex_index, map_id, coord_x, coord_y, coord_z, coord_x_max, coord_y_max,
	// coord_z_max, cost_multiplier, vertex_count
	input  logic [rpl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// operation
	input  logic [rpl_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// penalty, inside_region, map_has_regions
	output logic [rpl_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	localparam int MAXE  = BOX_ENTRIES > POLY_ENTRIES ? BOX_ENTRIES : POLY_ENTRIES;
	localparam int IDX_W = MAXE > 1 ? $clog2(MAXE) : 1;
	localparam int BA_W  = BOX_ENTRIES > 1 ? $clog2(BOX_ENTRIES) : 1;
	localparam int PA_W  = POLY_ENTRIES > 1 ? $clog2(POLY_ENTRIES) : 1;
	localparam int VDEPTH = POLY_ENTRIES * MAX_VERTICES;
	localparam int VA_W  = VDEPTH > 1 ? $clog2(VDEPTH) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int D_W   = COORD_W + 1;

	state_t state_q, state_d;

	logic [3:0]  in_slot;
	logic [2:0]  in_vi;
	logic [15:0] in_map;
	logic signed [COORD_W-1:0] in_x, in_y, in_z, in_xm, in_ym, in_zm;
	logic [7:0]  in_cost;
	logic [3:0]  in_cnt;
	op_e_t       in_op;
	logic        accept;

	assign in_slot = s_axis_tdata[3:0];
	assign in_vi   = s_axis_tdata[6:4];
	assign in_map  = s_axis_tdata[22:7];
	assign in_x    = s_axis_tdata[46:23];
	assign in_y    = s_axis_tdata[70:47];
	assign in_z    = s_axis_tdata[94:71];
	assign in_xm   = s_axis_tdata[118:95];
	assign in_ym   = s_axis_tdata[142:119];
	assign in_zm   = s_axis_tdata[166:143];
	assign in_cost = s_axis_tdata[174:167];
	assign in_cnt  = s_axis_tdata[178:175];
	assign in_op   = op_e_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	logic box_ok, poly_ok, vert_ok;
	assign box_ok  = int'(in_slot) < BOX_ENTRIES;
	assign poly_ok = int'(in_slot) < POLY_ENTRIES;
	assign vert_ok = poly_ok && (int'(in_vi) < MAX_VERTICES);

	// query registers
	logic signed [COORD_W-1:0] qx_q, qy_q, qz_q;
	logic [15:0]      qmap_q;
	logic [7:0]       worst_q, pcost_q;
	logic             has_q, inside_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] k_q, n_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic signed [D_W-1:0] a_q, b_q, c_q, d_q;
	logic signed [2*D_W-1:0] lhs_q, rhs_q;
	logic             m_valid_q;
	logic [9:0]       m_data_q;

	logic [BOX_ENTRIES-1:0] box_valid_q;
	logic [CNT_W-1:0]       poly_cnt_q [POLY_ENTRIES];

	box_entry_t box_w, box_r;
	poly_hdr_t  hdr_w, hdr_r;
	vertex_t    vert_w, vert_r;
	logic [VA_W-1:0] v_waddr, v_raddr, vbase;

	assign box_w = '{cost: in_cost, zmax: in_zm, ymax: in_ym, xmax: in_xm,
		zmin: in_z, ymin: in_y, xmin: in_x, map: in_map};
	assign hdr_w = '{cost: in_cost, zmax: in_zm, zmin: in_z, map: in_map};
	assign vert_w = '{y: in_y, x: in_x};
	assign v_waddr = VA_W'(int'(in_slot) * MAX_VERTICES + int'(in_vi));
	assign vbase = VA_W'(int'(idx_q[PA_W-1:0]) * MAX_VERTICES);

	rpl_ram #(.WIDTH($bits(box_entry_t)), .DEPTH(BOX_ENTRIES)) u_box_ram (
		.clk(clk), .we(accept && in_op == OP_BOX && box_ok), .waddr(BA_W'(in_slot)),
		.wdata(box_w), .raddr(idx_q[BA_W-1:0]), .rdata(box_r)
	);
	rpl_ram #(.WIDTH($bits(poly_hdr_t)), .DEPTH(POLY_ENTRIES)) u_hdr_ram (
		.clk(clk), .we(accept && in_op == OP_POLY_HDR && poly_ok), .waddr(PA_W'(in_slot)),
		.wdata(hdr_w), .raddr(idx_q[PA_W-1:0]), .rdata(hdr_r)
	);
	rpl_ram #(.WIDTH($bits(vertex_t)), .DEPTH(VDEPTH)) u_vert_ram (
		.clk(clk), .we(accept && in_op == OP_POLY_VERT && vert_ok), .waddr(v_waddr),
		.wdata(vert_w), .raddr(v_raddr), .rdata(vert_r)
	);

	// per-step decisions
	logic [CNT_W-1:0] cur_cnt;
	logic box_hit, band_ok, hdr_take, y_cross, last_edge, last_box, last_poly, hit, inside_nx;
	logic signed [2*D_W-1:0] mul_p;
	logic signed [D_W-1:0] mul_a, mul_b;

	assign cur_cnt = poly_cnt_q[idx_q[PA_W-1:0]];
	assign box_hit = qx_q >= box_r.xmin && qx_q <= box_r.xmax &&
		qy_q >= box_r.ymin && qy_q <= box_r.ymax &&
		qz_q >= box_r.zmin && qz_q <= box_r.zmax;
	assign band_ok  = qz_q >= hdr_r.zmin && qz_q <= hdr_r.zmax;
	assign hdr_take = (cur_cnt != '0) && (hdr_r.map == qmap_q);
	assign y_cross  = (vert_r.y > qy_q) != (prev_y_q > qy_q);
	assign last_edge = (k_q == n_q - CNT_W'(1));
	assign last_box  = (idx_q == IDX_W'(BOX_ENTRIES - 1));
	assign last_poly = (idx_q == IDX_W'(POLY_ENTRIES - 1));
	assign hit = (b_q > 0) ? (lhs_q < rhs_q) : (lhs_q > rhs_q);
	assign inside_nx = (state_q == ST_CMP) ? (inside_q ^ hit) : inside_q;
	assign mul_a = (state_q == ST_MUL1) ? a_q : c_q;
	assign mul_b = (state_q == ST_MUL1) ? b_q : d_q;
	assign mul_p = mul_a * mul_b;

	always_comb begin
		case (state_q)
			ST_HDR_EV: v_raddr = vbase + VA_W'(cur_cnt - CNT_W'(1));
			ST_V_PREV: v_raddr = vbase;
			default:   v_raddr = vbase + VA_W'(k_q + CNT_W'(1));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_op == OP_QUERY) state_d = ST_BOX_RD;
			end
			ST_BOX_RD: state_d = ST_BOX_EV;
			ST_BOX_EV: state_d = last_box ? ST_HDR_RD : ST_BOX_RD;
			ST_HDR_RD: state_d = ST_HDR_EV;
			ST_HDR_EV: begin
				if (hdr_take && band_ok) state_d = ST_V_PREV;
				else state_d = last_poly ? ST_DONE : ST_HDR_RD;
			end
			ST_V_PREV: state_d = ST_V_CUR;
			ST_V_CUR: begin
				if (y_cross) state_d = ST_MUL1;
				else if (last_edge) state_d = last_poly ? ST_DONE : ST_HDR_RD;
				else state_d = ST_V_CUR;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_CMP;
			ST_CMP: begin
				if (last_edge) state_d = last_poly ? ST_DONE : ST_HDR_RD;
				else state_d = ST_V_CUR;
			end
			ST_DONE: begin
				if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q <= '0;
			for (int i = 0; i < POLY_ENTRIES; i++) poly_cnt_q[i] <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept && in_op == OP_BOX && box_ok) box_valid_q[BA_W'(in_slot)] <= 1'b1;
			if (accept && in_op == OP_POLY_HDR && poly_ok) begin
				poly_cnt_q[PA_W'(in_slot)] <= (int'(in_cnt) > MAX_VERTICES) ?
					CNT_W'(MAX_VERTICES) : CNT_W'(in_cnt);
			end
			if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && in_op == OP_QUERY) begin
					qx_q <= in_x;
					qy_q <= in_y;
					qz_q <= in_z;
					qmap_q <= in_map;
					worst_q <= 8'd1;
					has_q <= 1'b0;
					idx_q <= '0;
				end
			end
			ST_BOX_EV: begin
				if (box_valid_q[idx_q[BA_W-1:0]] && box_r.map == qmap_q) begin
					has_q <= 1'b1;
					if (box_hit && box_r.cost > worst_q) worst_q <= box_r.cost;
				end
				idx_q <= last_box ? '0 : idx_q + IDX_W'(1);
			end
			ST_HDR_EV: begin
				if (hdr_take) has_q <= 1'b1;
				n_q <= cur_cnt;
				k_q <= '0;
				inside_q <= 1'b0;
				pcost_q <= hdr_r.cost;
				if (!(hdr_take && band_ok) && !last_poly) idx_q <= idx_q + IDX_W'(1);
			end
			ST_V_PREV: begin
				prev_x_q <= vert_r.x;
				prev_y_q <= vert_r.y;
			end
			ST_V_CUR: begin
				cur_x_q <= vert_r.x;
				cur_y_q <= vert_r.y;
				a_q <= D_W'(qx_q) - D_W'(vert_r.x);
				b_q <= D_W'(prev_y_q) - D_W'(vert_r.y);
				c_q <= D_W'(prev_x_q) - D_W'(vert_r.x);
				d_q <= D_W'(qy_q) - D_W'(vert_r.y);
				if (!y_cross) begin
					prev_x_q <= vert_r.x;
					prev_y_q <= vert_r.y;
					k_q <= k_q + CNT_W'(1);
					if (last_edge) begin
						if (inside_q && pcost_q > worst_q) worst_q <= pcost_q;
						if (!last_poly) idx_q <= idx_q + IDX_W'(1);
					end
				end
			end
			ST_MUL1: lhs_q <= mul_p;
			ST_MUL2: rhs_q <= mul_p;
			ST_CMP: begin
				inside_q <= inside_nx;
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
				k_q <= k_q + CNT_W'(1);
				if (last_edge) begin
					if (inside_nx && pcost_q > worst_q) worst_q <= pcost_q;
					if (!last_poly) idx_q <= idx_q + IDX_W'(1);
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					m_data_q <= {has_q, worst_q > 8'd1, worst_q};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - 10){1'b0}}, m_data_q};

`ifndef NO_ASSERTIONS
	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[8] == (m_axis_tdata[7:0] > 8'd1)))
		else $error("inside flag disagrees with penalty");
	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_V_CUR || state_q == ST_CMP) |-> (k_q < n_q))
		else $error("edge counter past vertex count");
	a_worst_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && $past(state_q) != ST_IDLE) |-> (worst_q >= $past(worst_q)))
		else $error("penalty fell during query");
`endif
endmodule
